FILE: sv/bb3_pkg.sv
package bb3_pkg;

    localparam int MaxWidth  = 4096;
    localparam int MaxHeight = 4096;

    localparam int DimW  = 13;                   // width of the size registers
    localparam int ColW  = $clog2(MaxWidth);     // column index / line buffer address
    localparam int RowW  = $clog2(MaxHeight) + 1;// row counter, holds the height itself
    localparam int PosW  = 12;                   // reported row and column
    localparam int PixW  = 24;
    localparam int SumW  = 12;                   // up to 9 * 255
    localparam int CntW  = 4;                    // 1 .. 9 neighbors
    localparam int RcpW  = 20;                   // reciprocal of the doubled count
    localparam int RcpSh = 20;

    localparam logic [1:0] CfgWidth  = 2'd0;
    localparam logic [1:0] CfgHeight = 2'd1;

    localparam logic ActPixel = 1'b0;
    localparam logic ActFlush = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_DIV  = 3'b100
    } t_state;

    typedef struct packed {
        logic [2:0][SumW-1:0] sum;   // red, green, blue
        logic [CntW-1:0]      cnt;
        logic [PosW-1:0]      row;
        logic [PosW-1:0]      col;
        logic                 last;
        logic                 frame;
    } t_pend;

    typedef struct packed {
        logic [2:0][7:0] rgb;
        logic [PosW-1:0] row;
        logic [PosW-1:0] col;
        logic            last;
        logic            frame;
    } t_result;

    // ceil(2^19 / n): multiplying 2*sum + n by it and dropping 20 bits gives
    // the exact quotient by 2*n for every sum the window can produce
    function automatic logic [RcpW-1:0] recip(input logic [CntW-1:0] n);
        logic [RcpW-1:0] r;
        unique case (n)
            4'd1:    r = 20'd524288;
            4'd2:    r = 20'd262144;
            4'd3:    r = 20'd174763;
            4'd4:    r = 20'd131072;
            4'd5:    r = 20'd104858;
            4'd6:    r = 20'd87382;
            4'd7:    r = 20'd74899;
            4'd8:    r = 20'd65536;
            4'd9:    r = 20'd58255;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

    // one channel of a three-pixel column, top and bottom taken when present
    function automatic logic [9:0] col_sum(input logic [PixW-1:0] top,
                                           input logic [PixW-1:0] mid,
                                           input logic [PixW-1:0] bot,
                                           input logic use_top,
                                           input logic use_bot,
                                           input int ch);
        logic [9:0] s;
        s = {2'b00, mid[PixW-1-8*ch -: 8]};
        if (use_top) s = s + {2'b00, top[PixW-1-8*ch -: 8]};
        if (use_bot) s = s + {2'b00, bot[PixW-1-8*ch -: 8]};
        return s;
    endfunction

endpackage

FILE: sv/box_blur_3x3_stream.sv
// Streaming 3x3 box blur over RGB pixels in raster order. Each result is the
// mean of the pixel's 3x3 neighborhood, counting only neighbors inside the
// frame (1 to 9), rounded half up. Results for row r-1 come out while row r
// arrives; after the last row, send image_width flush requests (action = 1)
// to drain the bottom row. A pixel request while flushing is expected, or a
// flush request while pixels are expected, is dropped with no result. Each
// accepted request gives zero, one or two results; last_of_run marks the final
// one and frame_done marks the bottom-right pixel. Writing either size
// register restarts the frame; sizes saturate to 1..4096.
// Each request that is not dropped passes a read of the two line buffers, a
// read-modify-write step, then one shared divider pass per result; the
// divider starts only once the output buffer has drained. Results drain from
// a two-entry output buffer while the next request is read.
module box_blur_3x3_stream (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [12:0]           i_cfg_data,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [7:0]            i_in_red,
    input  logic [7:0]            i_in_green,
    input  logic [7:0]            i_in_blue,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic [11:0]           o_out_row,
    output logic [11:0]           o_out_col,
    output logic                  o_last_of_run,
    output logic                  o_frame_done
);
    import bb3_pkg::*;

    // size registers and effective (saturated) sizes
    logic [DimW-1:0] r_cfg_width, r_cfg_height;
    logic [DimW-1:0] w_eff, h_eff;

    always_comb begin
        if (r_cfg_width == '0)                          w_eff = DimW'(1);
        else if (r_cfg_width > DimW'(MaxWidth))         w_eff = DimW'(MaxWidth);
        else                                            w_eff = r_cfg_width;
        if (r_cfg_height == '0)                         h_eff = DimW'(1);
        else if (r_cfg_height > DimW'(MaxHeight))       h_eff = DimW'(MaxHeight);
        else                                            h_eff = r_cfg_height;
    end

    t_state          r_state;
    logic [RowW-1:0] r_row_pos;
    logic [ColW-1:0] r_col_pos;

    // latched request
    logic            r_flush;
    logic [PixW-1:0] r_pix;
    logic [ColW-1:0] r_c;
    logic [RowW-1:0] r_row;

    // line buffers: previous row and the one before it
    logic [PixW-1:0] r_line_prev  [MaxWidth];
    logic [PixW-1:0] r_line_prev2 [MaxWidth];
    logic [PixW-1:0] r_mid_q, r_top_q;

    // two previous columns: [0..2] column c-2, [3..5] column c-1 (top, mid, bot)
    logic [PixW-1:0] r_win [6];

    // sums waiting for the divider, and the output buffer
    t_pend           r_pend [2];
    logic [1:0]      r_pend_cnt;
    logic            r_div_idx;
    t_result         r_res [2];
    logic [1:0]      r_res_cnt;
    logic            r_res_head;

    logic            in_take, out_take, req_drop;
    logic [ColW-1:0] c_in;
    logic            c_last_in;
    logic [1:0]      n_pend_cnt;
    logic            div_done;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_res_cnt != 2'd0);
    assign out_take    = o_out_valid && !i_out_stall;

    // clamp the column, decide whether this request fits the frame phase
    always_comb begin
        c_in      = ({1'b0, r_col_pos} >= w_eff) ? '0 : r_col_pos;
        c_last_in = (({1'b0, c_in} + DimW'(1)) >= w_eff);
        req_drop  = (i_action == ActPixel) ? (r_row_pos >= h_eff) : (r_row_pos < h_eff);
    end

    // frame position and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_cfg_width <= DimW'(640);
            r_cfg_height<= DimW'(480);
        end else begin
            if (i_cfg_we) begin
                // any size write restarts the frame
                unique case (i_cfg_index)
                    CfgWidth: begin
                        r_cfg_width <= i_cfg_data;
                        r_row_pos   <= '0;
                        r_col_pos   <= '0;
                    end
                    CfgHeight: begin
                        r_cfg_height <= i_cfg_data;
                        r_row_pos    <= '0;
                        r_col_pos    <= '0;
                    end
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take && !req_drop) begin
                        // advance the position now; the latched copy drives the math
                        if (c_last_in) begin
                            r_col_pos <= '0;
                            r_row_pos <= (i_action == ActFlush) ? '0 : r_row_pos + RowW'(1);
                        end else begin
                            r_col_pos <= c_in + ColW'(1);
                        end
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= (n_pend_cnt != 2'd0) ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    // hold until the output buffer has drained and the last sum is divided
                    if (r_res_cnt == 2'd0 && div_done) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // latch the request and read both line buffers at its column
    always_ff @(posedge i_clk) begin
        if (in_take && !req_drop) begin
            r_flush <= (i_action == ActFlush);
            r_pix   <= {i_in_red, i_in_green, i_in_blue};
            r_c     <= c_in;
            r_row   <= r_row_pos;
            r_mid_q <= r_line_prev[c_in];
            r_top_q <= r_line_prev2[c_in];
        end
    end

    // write back on pixel requests: the middle row moves up, the new pixel becomes the middle row
    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC && !r_flush) begin
            r_line_prev2[r_c] <= r_mid_q;
            r_line_prev[r_c]  <= r_pix;
        end
    end

    // window sums
    logic            use_top, use_bot, has_a, has_b, c_ge1, c_ge2;
    logic [1:0]      col_cnt;
    logic [9:0]      cs0 [3], cs1 [3], cs2 [3];
    t_pend           res_a, res_b;

    always_comb begin
        use_top = (r_row >= RowW'(2));
        use_bot = !r_flush;
        c_ge1   = (r_c >= ColW'(1));
        c_ge2   = (r_c >= ColW'(2));
        has_a   = (r_row >= RowW'(1)) && c_ge1;
        has_b   = (r_row >= RowW'(1)) && (({1'b0, r_c} + DimW'(1)) == w_eff);
        col_cnt = 2'd1 + {1'b0, use_top} + {1'b0, use_bot};
        for (int ch = 0; ch < 3; ch++) begin
            cs0[ch] = col_sum(r_win[0], r_win[1], r_win[2], use_top, use_bot, ch);
            cs1[ch] = col_sum(r_win[3], r_win[4], r_win[5], use_top, use_bot, ch);
            cs2[ch] = col_sum(r_top_q, r_mid_q, r_pix, use_top, use_bot, ch);
            res_a.sum[2-ch] = (c_ge2 ? {2'b00, cs0[ch]} : SumW'(0))
                              + {2'b00, cs1[ch]} + {2'b00, cs2[ch]};
            res_b.sum[2-ch] = (c_ge1 ? {2'b00, cs1[ch]} : SumW'(0)) + {2'b00, cs2[ch]};
        end
        res_a.cnt   = CntW'(col_cnt) * (c_ge2 ? CntW'(3) : CntW'(2));
        res_a.row   = PosW'(r_row - RowW'(1));
        res_a.col   = PosW'(r_c - ColW'(1));
        res_a.last  = !has_b;
        res_a.frame = 1'b0;
        res_b.cnt   = CntW'(col_cnt) * (c_ge1 ? CntW'(2) : CntW'(1));
        res_b.row   = PosW'(r_row - RowW'(1));
        res_b.col   = PosW'(r_c);
        res_b.last  = 1'b1;
        res_b.frame = r_flush;
        n_pend_cnt  = {1'b0, has_a} + {1'b0, has_b};
    end

    // shift the window and queue the sums
    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_top_q;
            r_win[4] <= r_mid_q;
            r_win[5] <= r_pix;
            r_pend[0] <= has_a ? res_a : res_b;
            r_pend[1] <= res_b;
        end
    end

    // divider: one result per cycle while the output buffer is empty, three channel lanes
    t_pend                     cur;
    logic [RcpW-1:0]           rcp;
    logic [SumW:0]             num [3];
    logic [SumW+RcpW:0]        prod [3];
    t_result                   q;

    always_comb begin
        cur      = r_pend[r_div_idx];
        rcp      = recip(cur.cnt);
        div_done = ({1'b0, r_div_idx} + 2'd1) == r_pend_cnt;
        for (int ch = 0; ch < 3; ch++) begin
            num[ch]  = {cur.sum[ch], 1'b0} + (SumW+1)'(cur.cnt);
            prod[ch] = (SumW+RcpW+1)'(num[ch]) * (SumW+RcpW+1)'(rcp);
            q.rgb[ch] = prod[ch][RcpSh +: 8];
        end
        q.row   = cur.row;
        q.col   = cur.col;
        q.last  = cur.last;
        q.frame = cur.frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= '0;
            r_div_idx  <= 1'b0;
            r_res_cnt  <= '0;
            r_res_head <= 1'b0;
        end else begin
            if (r_state == S_CALC) begin
                r_pend_cnt <= n_pend_cnt;
                r_div_idx  <= 1'b0;
            end
            if (out_take) begin
                r_res_head <= !r_res_head;
                r_res_cnt  <= r_res_cnt - 2'd1;
            end
            if (r_state == S_DIV && r_res_cnt == 2'd0) begin
                r_div_idx <= !r_div_idx;
                if (div_done) begin
                    // publish the whole run at once
                    r_res_cnt  <= r_pend_cnt;
                    r_res_head <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && r_res_cnt == 2'd0) r_res[r_div_idx] <= q;
    end

    t_result head;
    assign head          = r_res[r_res_head];
    assign o_out_red     = head.rgb[2];
    assign o_out_green   = head.rgb[1];
    assign o_out_blue    = head.rgb[0];
    assign o_out_row     = head.row;
    assign o_out_col     = head.col;
    assign o_last_of_run = head.last;
    assign o_frame_done  = head.frame;

endmodule
